@@ rtl/core/fcsg_pkg.sv @@
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants of the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

	localparam int CoordW    = 10;
	localparam int RadW      = 6;
	localparam int SpanW     = 12;
	localparam int OffW      = 6;
	localparam int DecW      = 10;
	localparam int ResultCap = 64;
	localparam int CntW      = $clog2(ResultCap + 1);
	localparam int QueueDepth = 2;
	localparam int QPtrW     = $clog2(QueueDepth);
	localparam int QCntW     = $clog2(QueueDepth + 1);

	localparam logic [RadW-1:0]   MaxRadius = RadW'(63);
	localparam logic [CoordW-1:0] CoordMax  = CoordW'(1023);

	typedef struct packed {
		logic [CoordW-1:0] center_x;
		logic [CoordW-1:0] center_y;
		logic [RadW-1:0]   radius;
	} req_t;

	typedef struct packed {
		logic signed [SpanW-1:0] wide_left;
		logic signed [SpanW-1:0] wide_right;
		logic signed [SpanW-1:0] narrow_left;
		logic signed [SpanW-1:0] narrow_right;
		logic signed [SpanW-1:0] inner_top_row;
		logic signed [SpanW-1:0] inner_bottom_row;
		logic signed [SpanW-1:0] outer_top_row;
		logic signed [SpanW-1:0] outer_bottom_row;
		logic                    last;
	} span_t;

	// head of the request queue as seen by the back end
	typedef struct packed {
		logic valid;
		req_t req;
	} head_t;

endpackage

@@ rtl/core/fcsg_if.sv @@
// ----------------------------------------------------------------------------
// fcsg_if
// Valid/ready channels for circle requests and span results.
// ----------------------------------------------------------------------------
interface fcsg_req_if;
	import fcsg_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fcsg_span_if;
	import fcsg_pkg::*;

	logic  valid;
	logic  ready;
	span_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/fcsg_front.sv @@
// ----------------------------------------------------------------------------
// fcsg_front
// Accepts circle requests, clamps them to range and queues them for the
// back end.
// ----------------------------------------------------------------------------
module fcsg_front (
	input  logic           clk,
	input  logic           arst_n,
	fcsg_req_if.sink       request,
	input  logic           pop,
	output fcsg_pkg::head_t head
);
	import fcsg_pkg::*;

	req_t             entry_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	req_t             clamped;
	logic             push;

	always_comb begin
		clamped = request.data;
		if (request.data.center_x > CoordMax) begin
			clamped.center_x = CoordMax;
		end
		if (request.data.center_y > CoordMax) begin
			clamped.center_y = CoordMax;
		end
		if (request.data.radius > MaxRadius) begin
			clamped.radius = MaxRadius;
		end
	end

	assign request.ready = (count_q != QCntW'(QueueDepth));
	assign push          = request.valid && request.ready;

	assign head.valid = (count_q != '0);
	assign head.req   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCntW'(1);
				2'b01:   count_q <= count_q - QCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/fcsg_back.sv @@
// ----------------------------------------------------------------------------
// fcsg_back
// Runs the Andres circle iteration for one queued request at a time and
// emits one span result per iteration through an output register.
// ----------------------------------------------------------------------------
module fcsg_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fcsg_pkg::head_t head,
	output logic           pop,
	fcsg_span_if.source    span
);
	import fcsg_pkg::*;

	logic                   active_q;
	logic [OffW-1:0]        ox_q;
	logic [OffW-1:0]        oy_q;
	logic signed [DecW-1:0] d_q;
	logic [CntW-1:0]        cnt_q;
	logic [CoordW-1:0]      cx_q;
	logic [CoordW-1:0]      cy_q;
	logic [RadW-1:0]        rad_q;
	logic                   out_valid_q;
	span_t                  out_q;

	logic                   emit;
	logic signed [DecW:0]   d_ext;
	logic signed [DecW:0]   two_ox;
	logic signed [DecW:0]   two_gap;
	logic signed [DecW:0]   d_next;
	logic signed [7:0]      ox_next;
	logic signed [7:0]      oy_next;
	logic                   done;
	logic signed [SpanW-1:0] x_s;
	logic signed [SpanW-1:0] y_s;
	logic signed [SpanW-1:0] ox_s;
	logic signed [SpanW-1:0] oy_s;

	assign emit = active_q && (!out_valid_q || span.ready);
	assign pop  = !active_q && head.valid;

	// one step of the decision term
	always_comb begin
		d_ext   = (DecW+1)'(d_q);
		two_ox  = (DecW+1)'({ox_q, 1'b0});
		two_gap = (DecW+1)'({1'b0, rad_q, 1'b0}) - (DecW+1)'({oy_q, 1'b0});
		ox_next = 8'(ox_q);
		oy_next = 8'(oy_q);
		if (d_ext >= two_ox) begin
			d_next  = d_ext - two_ox - (DecW+1)'(1);
			ox_next = 8'(ox_q) + 8'sd1;
		end else if (d_ext < two_gap) begin
			d_next  = d_ext + (DecW+1)'({oy_q, 1'b0}) - (DecW+1)'(1);
			oy_next = 8'(oy_q) - 8'sd1;
		end else begin
			d_next  = d_ext + (DecW+1)'({oy_q, 1'b0}) - two_ox - (DecW+1)'(2);
			oy_next = 8'(oy_q) - 8'sd1;
			ox_next = 8'(ox_q) + 8'sd1;
		end
		done = (oy_next < ox_next) || (cnt_q == CntW'(ResultCap - 1));
	end

	assign x_s  = SpanW'(cx_q);
	assign y_s  = SpanW'(cy_q);
	assign ox_s = SpanW'(ox_q);
	assign oy_s = SpanW'(oy_q);

	always_ff @(posedge clk) begin
		if (pop) begin
			cx_q  <= head.req.center_x;
			cy_q  <= head.req.center_y;
			rad_q <= head.req.radius;
			ox_q  <= '0;
			oy_q  <= OffW'(head.req.radius);
			d_q   <= DecW'(head.req.radius) - DecW'(1);
		end else if (emit) begin
			ox_q <= OffW'(ox_next);
			oy_q <= OffW'(oy_next);
			d_q  <= DecW'(d_next);
		end
		if (emit) begin
			out_q.wide_left        <= x_s - oy_s;
			out_q.wide_right       <= x_s + oy_s;
			out_q.narrow_left      <= x_s - ox_s;
			out_q.narrow_right     <= x_s + ox_s;
			out_q.inner_top_row    <= y_s - ox_s;
			out_q.inner_bottom_row <= y_s + ox_s;
			out_q.outer_top_row    <= y_s - oy_s;
			out_q.outer_bottom_row <= y_s + oy_s;
			out_q.last             <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + CntW'(1);
				if (done) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (span.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign span.valid = out_valid_q;
	assign span.data  = out_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !active_q)
		else $error("request taken while a circle is in progress");

	a_loop_inv: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (oy_q >= ox_q))
		else $error("offset y fell below offset x while active");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && done) |=> (!active_q && span.valid && span.data.last))
		else $error("final iteration did not end the circle");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q < CntW'(ResultCap)))
		else $error("iteration count beyond cap");

endmodule

@@ rtl/core/filled_circle_span_generator.sv @@
// An accepted request is queued, then loaded once the iteration unit is idle.
// Throughput: one span result per cycle while the output is not stalled; a circle of
//   radius r yields about 0.7*r + 1 results, at most 64, after a load step.
// Requests queue two deep, so the next one is taken while a circle is drawn.
// Reset (arst_n low, asynchronous) empties the queue and idles the iteration unit.
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Produces the horizontal spans of a filled circle, one result per step of
// the Andres integer circle algorithm.
// ----------------------------------------------------------------------------
module filled_circle_span_generator (
	input  logic        clk,
	input  logic        arst_n,
	fcsg_req_if.sink    request,
	fcsg_span_if.source span
);
	import fcsg_pkg::*;

	head_t head;
	logic  pop;

	fcsg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.pop     (pop),
		.head    (head)
	);

	fcsg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.span   (span)
	);

endmodule

@@ tb/sv/fcsg_span_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_span_checker
// Watches the request and span channels of the filled circle span generator.
// Every accepted circle request is expanded into the spans that the Andres
// fill should produce. Each accepted span result is then compared field by
// field with the oldest span still due.
// ----------------------------------------------------------------------------
module fcsg_span_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  fcsg_pkg::req_t  req_data,
	input  logic            span_valid,
	input  logic            span_ready,
	input  fcsg_pkg::span_t span_data,
	output int              errors,
	output int              outstanding
);
	import fcsg_pkg::*;

	span_t spans_due[$];

	// where the iteration of the circle last expanded stopped
	int                arc_x;
	int                arc_y;
	int                arc_err;

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	function automatic void plot_circle(req_t r);
		int    cx;
		int    cy;
		int    rad;
		int    count;
		span_t s;
		cx  = r.center_x;
		cy  = r.center_y;
		rad = r.radius;
		if (cx > CoordMax) cx = CoordMax;
		if (cy > CoordMax) cy = CoordMax;
		if (rad > MaxRadius) rad = MaxRadius;
		arc_x    = 0;
		arc_y    = rad;
		arc_err  = rad - 1;
		count    = 0;
		while (arc_y >= arc_x && count < ResultCap) begin
			s.wide_left        = SpanW'(cx - arc_y);
			s.wide_right       = SpanW'(cx + arc_y);
			s.narrow_left      = SpanW'(cx - arc_x);
			s.narrow_right     = SpanW'(cx + arc_x);
			s.inner_top_row    = SpanW'(cy - arc_x);
			s.inner_bottom_row = SpanW'(cy + arc_x);
			s.outer_top_row    = SpanW'(cy - arc_y);
			s.outer_bottom_row = SpanW'(cy + arc_y);
			count++;
			if (arc_err >= 2 * arc_x) begin
				arc_err -= 2 * arc_x + 1;
				arc_x++;
			end else if (arc_err < 2 * (rad - arc_y)) begin
				arc_err += 2 * arc_y - 1;
				arc_y--;
			end else begin
				arc_err += 2 * (arc_y - arc_x - 1);
				arc_y--;
				arc_x++;
			end
			// flag the step after which the loop stops, by crossing or by the cap
			s.last = (arc_y < arc_x) || (count == ResultCap);
			spans_due.push_back(s);
		end
	endfunction

	task automatic check_field(input string field, input logic [SpanW-1:0] due,
			input logic [SpanW-1:0] got);
		if (got !== due) begin
			$display("%0t: %s expected %0d, got %0d", $time, field,
				$signed(due), $signed(got));
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_t due;
		if (!arst_n) begin
			spans_due.delete();
			arc_x       = 0;
			arc_y       = 0;
			arc_err     = 0;
			outstanding = 0;
		end else begin
			if (req_valid && req_ready)
				plot_circle(req_data);
			if (span_valid && span_ready) begin
				if (spans_due.size() == 0) begin
					$display("%0t: span result with no request pending", $time);
					errors++;
				end else begin
					due = spans_due.pop_front();
					check_field("wide_left", due.wide_left, span_data.wide_left);
					check_field("wide_right", due.wide_right, span_data.wide_right);
					check_field("narrow_left", due.narrow_left, span_data.narrow_left);
					check_field("narrow_right", due.narrow_right, span_data.narrow_right);
					check_field("inner_top_row", due.inner_top_row,
						span_data.inner_top_row);
					check_field("inner_bottom_row", due.inner_bottom_row,
						span_data.inner_bottom_row);
					check_field("outer_top_row", due.outer_top_row,
						span_data.outer_top_row);
					check_field("outer_bottom_row", due.outer_bottom_row,
						span_data.outer_bottom_row);
					check_field("last", SpanW'(due.last), SpanW'(span_data.last));
				end
			end
			outstanding = spans_due.size();
		end
	end

endmodule

@@ tb/sv/filled_circle_span_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_generator_tb
// Feeds circle requests to the span generator: a directed set of edge
// centers and radii, then random circles, with random stalls on both
// channels until the final stretch. A checker beside the block predicts
// and compares every span result.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_tb;
	import fcsg_pkg::*;

	localparam int RandomCircles = 254;
	localparam int CalmCircles   = 70;
	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles   = 20;

	logic clk;
	logic arst_n;
	bit   idle_en;
	int   stall_left;
	int   quiet_cycles;
	int   errors;
	int   outstanding;

	fcsg_req_if  req_ch();
	fcsg_span_if span_ch();

	filled_circle_span_generator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.span    (span_ch)
	);

	fcsg_span_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.req_data    (req_ch.data),
		.span_valid  (span_ch.valid),
		.span_ready  (span_ch.ready),
		.span_data   (span_ch.data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// span sink: random stall bursts while idling is on
	initial begin
		stall_left    = 0;
		span_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 10);
			if (stall_left > 0) begin
				span_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				span_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (span_ch.valid && span_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("filled_circle_span_generator_tb: errors");
				$finish;
			end
		end
	end

	// called at a rising edge; returns at the edge that accepts the request
	task automatic send_circle(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
			input logic [RadW-1:0] rad);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.data.center_x <= cx;
		req_ch.data.center_y <= cy;
		req_ch.data.radius   <= rad;
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
	endtask

	function automatic logic [CoordW-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0:       return CoordW'($urandom_range(0, 63));
			1:       return CoordW'($urandom_range(960, 1023));
			default: return CoordW'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [RadW-1:0] pick_radius();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return MaxRadius;
			2:       return RadW'($urandom_range(1, 3));
			default: return RadW'($urandom_range(0, 63));
		endcase
	endfunction

	initial begin
		arst_n       = 1'b0;
		idle_en      = 1'b0;
		quiet_cycles = 0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero radius gives a single point; corners, edges and the largest radius
		send_circle(0, 0, 0);
		send_circle(CoordMax, CoordMax, 0);
		send_circle(512, 512, 0);
		send_circle(0, 0, MaxRadius);
		send_circle(CoordMax, CoordMax, MaxRadius);
		send_circle(0, CoordMax, MaxRadius);
		send_circle(CoordMax, 0, MaxRadius);
		send_circle(512, 512, 1);
		send_circle(512, 512, 2);
		send_circle(512, 512, 3);
		send_circle(341, 682, 42);
		send_circle(682, 341, 21);
		send_circle(1, 1, 1);
		send_circle(CoordMax - 1, CoordMax - 1, 62);
		send_circle(0, 0, 32);
		send_circle(CoordMax, CoordMax, 31);

		idle_en = 1'b1;
		for (int n = 0; n < RandomCircles; n++) begin
			// no idling on either side for the final stretch
			if (n == RandomCircles - CalmCircles)
				idle_en = 1'b0;
			send_circle(pick_coord(), pick_coord(), pick_radius());
		end
		req_ch.valid <= 1'b0;

		// let the checker take the last request before looking at its backlog
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("filled_circle_span_generator_tb: clean");
		else
			$display("filled_circle_span_generator_tb: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/fcsg_pkg.sv
rtl/core/fcsg_if.sv
rtl/core/fcsg_front.sv
rtl/core/fcsg_back.sv
rtl/core/filled_circle_span_generator.sv
tb/sv/fcsg_span_checker.sv
tb/sv/filled_circle_span_generator_tb.sv
